FILE: hdl/byte_stack_memory_push_pop_core_assert.svh
`ifndef BYTE_STACK_MEMORY_PUSH_POP_CORE_ASSERT_SVH
`define BYTE_STACK_MEMORY_PUSH_POP_CORE_ASSERT_SVH

// condition that holds at every edge out of reset
`define BSM_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence that follows in the cycle after a trigger
`define BSM_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bsm_pkg.sv
package bsm_pkg;

  localparam int unsigned SP_W   = 17;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned DATA_W = 64;

  localparam logic [7:0] GUARD_BYTE = 8'hfe;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_LOAD  = 2'd2,
    MODE_STORE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_WIDTH = 2'd1,
    STATUS_RANGE     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clear_en;
    logic latch;
    logic access;
    logic finish;
  } bsm_cmd_t;

  typedef struct packed {
    logic clear_done;
  } bsm_stat_t;

endpackage

FILE: hdl/bsm_if.sv
interface bsm_req_if import bsm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [1:0]        width_code;
  logic [SP_W-1:0]   stack_pointer_in;
  logic [ADDR_W-1:0] byte_address;
  logic [DATA_W-1:0] write_value;

  modport source (
    output valid, mode, width_code, stack_pointer_in, byte_address, write_value,
    input  ready
  );
  modport sink (
    input  valid, mode, width_code, stack_pointer_in, byte_address, write_value,
    output ready
  );
endinterface

interface bsm_rsp_if import bsm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [SP_W-1:0]   stack_pointer_out;
  logic [1:0]        status;

  modport source (
    output valid, read_data, stack_pointer_out, status,
    input  ready
  );
  modport sink (
    input  valid, read_data, stack_pointer_out, status,
    output ready
  );
endinterface

FILE: hdl/bsm_ctrl.sv
`include "byte_stack_memory_push_pop_core_assert.svh"

module bsm_ctrl import bsm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  input  bsm_stat_t stat,
  output bsm_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   out_full;
  logic   out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (stat.clear_done) state_next = ST_IDLE;
      ST_IDLE:   if (req_valid) state_next = ST_ACCESS;
      ST_ACCESS: state_next = ST_FINISH;
      ST_FINISH: if (!out_full || rsp_ready) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd.clear_en = (state == ST_CLEAR);
    cmd.latch    = (state == ST_IDLE) && req_valid;
    cmd.access   = (state == ST_ACCESS);
    cmd.finish   = (state == ST_FINISH) && (!out_full || rsp_ready);
    req_ready    = (state == ST_IDLE);
    rsp_valid    = out_full;
  end

  always_comb begin
    priority if (cmd.finish) begin
      out_full_next = 1'b1;
    end else if (rsp_ready) begin
      out_full_next = 1'b0;
    end else begin
      out_full_next = out_full;
    end
  end

  `BSM_ASSERT_ALWAYS(a_accept_only_idle, !(req_valid && req_ready) || state == ST_IDLE, "beat accepted outside idle")
  `BSM_ASSERT_NEXT(a_access_after_accept, req_valid && req_ready, state == ST_ACCESS, "no access after accepted beat")
  `BSM_ASSERT_ALWAYS(a_no_overwrite, !(cmd.finish && out_full && !rsp_ready), "result overwritten before taken")

endmodule

FILE: hdl/bsm_datapath.sv
module bsm_datapath import bsm_pkg::*; #(
  parameter int unsigned STACK_BYTES = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  bsm_cmd_t          cmd,
  output bsm_stat_t         stat,
  input  logic [1:0]        mode,
  input  logic [1:0]        width_code,
  input  logic [SP_W-1:0]   stack_pointer_in,
  input  logic [ADDR_W-1:0] byte_address,
  input  logic [DATA_W-1:0] write_value,
  output logic [DATA_W-1:0] read_data,
  output logic [SP_W-1:0]   stack_pointer_out,
  output logic [1:0]        status
);

  localparam int unsigned ROWS = (STACK_BYTES + 7) / 8;
  localparam int unsigned RW   = $clog2(ROWS);
  localparam int unsigned AW   = RW + 3;
  localparam int unsigned CW   = ((AW > SP_W) ? AW : SP_W) + 1;
  localparam logic [CW-1:0] LIMIT = CW'(STACK_BYTES);

  // latched beat
  mode_t             mode_q;
  logic [1:0]        wcode_q;
  logic [SP_W-1:0]   sp_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] wval_q;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_q  <= mode_t'(mode);
      wcode_q <= width_code;
      sp_q    <= stack_pointer_in;
      addr_q  <= byte_address;
      wval_q  <= write_value;
    end
  end

  // clearing pass row counter
  logic [RW-1:0] clear_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_row <= '0;
    end else if (cmd.clear_en) begin
      clear_row <= clear_row + RW'(1);
    end
  end

  assign stat.clear_done = (clear_row == RW'(ROWS - 1));

  // range checks and address
  logic [3:0]    n4;
  logic [CW-1:0] n_ext;
  logic [CW-1:0] sp_ext;
  logic [CW-1:0] addr_ext;
  logic [CW-1:0] base;
  logic          bad_width;
  logic          range_ok;
  logic          ok;
  logic          do_write;
  logic          do_read;
  status_t       status_c;
  logic [SP_W-1:0] sp_c;
  logic [2:0]    offset;
  logic [RW-1:0] row;
  logic [RW-1:0] row_inc;

  always_comb begin
    n4        = 4'd1 << wcode_q;
    n_ext     = CW'(n4);
    sp_ext    = CW'(sp_q);
    addr_ext  = CW'(addr_q);
    bad_width = (mode_q == MODE_PUSH || mode_q == MODE_POP) && (wcode_q == 2'd0);
    unique case (mode_q)
      MODE_PUSH: begin
        range_ok = (sp_ext >= n_ext) && (sp_ext <= LIMIT);
        base     = sp_ext - n_ext;
      end
      MODE_POP: begin
        range_ok = (sp_ext + n_ext) <= LIMIT;
        base     = sp_ext;
      end
      default: begin
        range_ok = (addr_ext + n_ext) <= LIMIT;
        base     = addr_ext;
      end
    endcase
    ok       = !bad_width && range_ok;
    do_write = ok && (mode_q == MODE_PUSH || mode_q == MODE_STORE);
    do_read  = ok && (mode_q == MODE_POP || mode_q == MODE_LOAD);
    priority if (bad_width) begin
      status_c = STATUS_BAD_WIDTH;
    end else if (!range_ok) begin
      status_c = STATUS_RANGE;
    end else begin
      status_c = STATUS_OK;
    end
    priority if (ok && mode_q == MODE_PUSH) begin
      sp_c = base[SP_W-1:0];
    end else if (ok && mode_q == MODE_POP) begin
      sp_c = sp_q + SP_W'(n4);
    end else begin
      sp_c = sp_q;
    end
    offset  = base[2:0];
    row     = base[AW-1:3];
    row_inc = row + RW'(1);
  end

  // byte banks, bank b holds bytes whose address is b modulo eight
  logic [2*DATA_W-1:0] wrot_wide;
  logic [DATA_W-1:0]   wrot;
  logic [DATA_W-1:0]   bank_word;

  assign wrot_wide = {wval_q, wval_q} << {offset, 3'b000};
  assign wrot      = wrot_wide[2*DATA_W-1:DATA_W];

  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [7:0]    mem [ROWS];
    logic [2:0]    lane;
    logic          en;
    logic [RW-1:0] bank_row;
    logic [7:0]    bank_q;

    always_comb begin
      lane     = 3'(b) - offset;
      en       = {1'b0, lane} < n4;
      bank_row = cmd.clear_en ? clear_row : ((3'(b) < offset) ? row_inc : row);
    end

    always_ff @(posedge clk) begin
      if (cmd.clear_en || (cmd.access && do_write && en)) begin
        mem[bank_row] <= cmd.clear_en ? GUARD_BYTE : wrot[b*8 +: 8];
      end
      if (cmd.access && do_read && en) begin
        bank_q <= mem[bank_row];
      end
    end

    assign bank_word[b*8 +: 8] = bank_q;
  end

  // per-beat result held between access and finish
  status_t         status_q;
  logic [SP_W-1:0] sp_out_q;
  logic            rd_q;
  logic [2:0]      off_q;
  logic [3:0]      n_q;

  always_ff @(posedge clk) begin
    if (cmd.access) begin
      status_q <= status_c;
      sp_out_q <= sp_c;
      rd_q     <= do_read;
      off_q    <= offset;
      n_q      <= n4;
    end
  end

  logic [2*DATA_W-1:0] rrot_wide;
  logic [DATA_W-1:0]   rd_c;

  assign rrot_wide = {bank_word, bank_word} >> {off_q, 3'b000};

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      rd_c[k*8 +: 8] = (rd_q && (4'(k) < n_q)) ? rrot_wide[k*8 +: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      read_data         <= rd_c;
      stack_pointer_out <= sp_out_q;
      status            <= status_q;
    end
  end

endmodule

FILE: hdl/byte_stack_memory_push_pop_core.sv
// steps per request beat: accept and latch, bank access, result register
// a new request beat is accepted only after the previous one has been finished
// eight byte banks give any 1, 2, 4 or 8 byte access, aligned or not, in a single bank access
// reset: a clearing pass writes 0xfe to all memory, one row of eight bytes a cycle,
// over all ceil(STACK_BYTES / 8) rows before the first request beat is accepted
module byte_stack_memory_push_pop_core import bsm_pkg::*; #(
  parameter int unsigned STACK_BYTES = 65536
) (
  input logic       clk,
  input logic       rst,
  bsm_req_if.sink   req,
  bsm_rsp_if.source rsp
);

  bsm_cmd_t  cmd;
  bsm_stat_t stat;

  bsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bsm_datapath #(
    .STACK_BYTES (STACK_BYTES)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .mode              (req.mode),
    .width_code        (req.width_code),
    .stack_pointer_in  (req.stack_pointer_in),
    .byte_address      (req.byte_address),
    .write_value       (req.write_value),
    .read_data         (rsp.read_data),
    .stack_pointer_out (rsp.stack_pointer_out),
    .status            (rsp.status)
  );

endmodule

FILE: tb/byte_stack_memory_push_pop_core_tb.sv
module byte_stack_memory_push_pop_core_tb import bsm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STACK_BYTES = 65536;
  localparam int unsigned IDX_W = $clog2(STACK_BYTES);

  typedef struct packed {
    mode_t             mode;
    logic [1:0]        width_code;
    logic [SP_W-1:0]   sp;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] value;
  } stack_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [SP_W-1:0]   sp;
    status_t           status;
  } stack_rsp_t;

  logic clk;
  logic rst;

  bsm_req_if req ();
  bsm_rsp_if rsp ();

  byte_stack_memory_push_pop_core #(.STACK_BYTES(STACK_BYTES)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  logic [7:0]  mem_image   [STACK_BYTES];
  bit          mem_written [STACK_BYTES];
  int unsigned recent_writes [$];
  int unsigned sp_track = STACK_BYTES;

  stack_rsp_t  pending_rsp [$];
  int unsigned mismatch_count = 0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // response side: random stalls, plus a long hold-off on request
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic bit span_fits(int unsigned base, int unsigned n);
    return base <= STACK_BYTES && n <= STACK_BYTES - base;
  endfunction

  // true when a pop or load would touch a byte never written since reset
  function automatic bit reads_unwritten(stack_req_t b);
    int unsigned n;
    int unsigned base;
    n = 1 << b.width_code;
    if (b.mode == MODE_POP && n > 1) base = 32'(b.sp);
    else if (b.mode == MODE_LOAD) base = 32'(b.addr);
    else return 1'b0;
    if (!span_fits(base, n)) return 1'b0;
    for (int i = 0; i < n; i++)
      if (!mem_written[IDX_W'(base + i)]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic stack_rsp_t predict_access(stack_req_t b);
    stack_rsp_t  r;
    int unsigned n;
    int unsigned base;
    n = 1 << b.width_code;
    r.read_data = '0;
    r.sp = b.sp;
    r.status = STATUS_OK;
    if (b.mode == MODE_PUSH) base = 32'(b.sp) - n;
    else if (b.mode == MODE_POP) base = 32'(b.sp);
    else base = 32'(b.addr);
    if ((b.mode == MODE_PUSH || b.mode == MODE_POP) && n == 1) begin
      r.status = STATUS_BAD_WIDTH;
    end else if ((b.mode == MODE_PUSH && 32'(b.sp) < n) || !span_fits(base, n)) begin
      r.status = STATUS_RANGE;
    end else begin
      for (int i = 0; i < n; i++) begin
        if (b.mode == MODE_PUSH || b.mode == MODE_STORE) begin
          mem_image[IDX_W'(base + i)] = b.value[8*i +: 8];
          mem_written[IDX_W'(base + i)] = 1'b1;
        end else begin
          r.read_data[8*i +: 8] = mem_image[IDX_W'(base + i)];
        end
      end
      if (b.mode == MODE_PUSH || b.mode == MODE_STORE) begin
        recent_writes.push_back(base);
        if (recent_writes.size() > 64) void'(recent_writes.pop_front());
      end
      if (b.mode == MODE_PUSH) r.sp = SP_W'(base);
      else if (b.mode == MODE_POP) r.sp = SP_W'(32'(b.sp) + n);
      if (b.mode == MODE_PUSH || b.mode == MODE_POP) sp_track = 32'(r.sp);
    end
    return r;
  endfunction

  // one request beat; valid stays high after acceptance until the next call decides
  task automatic drive_request(stack_req_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid            <= 1'b1;
    req.mode             <= b.mode;
    req.width_code       <= b.width_code;
    req.stack_pointer_in <= b.sp;
    req.byte_address     <= b.addr;
    req.write_value      <= b.value;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    pending_rsp.push_back(predict_access(b));
  endtask

  always @(posedge clk) begin : rsp_check
    stack_rsp_t want;
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("response beat with no request outstanding");
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.read_data !== want.read_data)
          report_mismatch($sformatf("read_data %h, want %h", rsp.read_data, want.read_data));
        if (rsp.stack_pointer_out !== want.sp)
          report_mismatch($sformatf("stack_pointer_out %h, want %h",
                                    rsp.stack_pointer_out, want.sp));
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", rsp.status, want.status));
      end
    end
  end

  function automatic stack_req_t beat(mode_t m, logic [1:0] wc, logic [SP_W-1:0] sp,
                                      logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] value);
    stack_req_t b;
    b.mode = m;
    b.width_code = wc;
    b.sp = sp;
    b.addr = addr;
    b.value = value;
    return b;
  endfunction

  // load near something written lately, falling back to a single known byte
  function automatic stack_req_t pick_load(stack_req_t b);
    int unsigned base;
    b.mode = MODE_LOAD;
    base = recent_writes[$urandom_range(recent_writes.size() - 1)];
    for (int k = 0; k < 8; k++) begin
      base = recent_writes[$urandom_range(recent_writes.size() - 1)];
      b.width_code = 2'($urandom_range(3));
      b.addr = ADDR_W'(base + $urandom_range(14) - 7);
      if (!reads_unwritten(b)) return b;
    end
    b.width_code = 2'd0;
    b.addr = ADDR_W'(base);
    return b;
  endfunction

  function automatic stack_req_t make_random_item();
    stack_req_t  b;
    int unsigned pick;
    if ($urandom_range(49) == 0) sp_track = $urandom_range(STACK_BYTES, 16);
    b.mode = MODE_STORE;
    b.width_code = 2'($urandom_range(3));
    b.sp = SP_W'(sp_track);
    b.addr = ADDR_W'($urandom);
    b.value = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 30 || (pick < 55 && sp_track < 16)) begin
      b.mode = MODE_PUSH;
      b.width_code = 2'($urandom_range(3, 1));
    end else if (pick < 55) begin
      b.mode = MODE_POP;
      b.width_code = 2'($urandom_range(3, 1));
      while (b.width_code > 1 && reads_unwritten(b)) b.width_code--;
      if (reads_unwritten(b)) b.mode = MODE_PUSH;
    end else if (pick < 72) begin
      b.mode = MODE_STORE;
    end else if (pick < 90) begin
      b = pick_load(b);
    end else begin
      b.mode = mode_t'(2'($urandom_range(3)));
      b.sp = SP_W'($urandom);
    end
    if (reads_unwritten(b)) b.mode = MODE_STORE;
    return b;
  endfunction

  task automatic test_load_store_edges();
    drive_request(beat(MODE_STORE, 2'd3, '0, 16'h0000, 64'h0123_4567_89ab_cdef));
    drive_request(beat(MODE_LOAD,  2'd3, '0, 16'h0000, '0));
    drive_request(beat(MODE_LOAD,  2'd0, '0, 16'h0007, '0));
    drive_request(beat(MODE_LOAD,  2'd1, '0, 16'h0003, '0));
    drive_request(beat(MODE_LOAD,  2'd2, '0, 16'h0001, '0));
    drive_request(beat(MODE_STORE, 2'd3, '0, 16'hfff8, '1));
    drive_request(beat(MODE_STORE, 2'd0, '0, 16'hffff, 64'h0000_0000_0000_005a));
    drive_request(beat(MODE_LOAD,  2'd3, '0, 16'hfff8, '0));
    drive_request(beat(MODE_LOAD,  2'd0, '0, 16'hffff, '0));
    // last byte past the end
    drive_request(beat(MODE_LOAD,  2'd1, '0, 16'hffff, '0));
    drive_request(beat(MODE_STORE, 2'd3, '0, 16'hfff9, 64'h1111_2222_3333_4444));
    drive_request(beat(MODE_LOAD,  2'd2, '0, 16'hfffc, '0));
  endtask

  task automatic test_push_pop_edges();
    drive_request(beat(MODE_PUSH, 2'd3, 17'h10000, '0, 64'hfedc_ba98_7654_3210));
    drive_request(beat(MODE_POP,  2'd3, 17'h0fff8, '0, '0));
    drive_request(beat(MODE_PUSH, 2'd1, 17'h00002, '0, 64'hffff_ffff_ffff_a55a));
    drive_request(beat(MODE_POP,  2'd1, 17'h00000, '0, '0));
    // pointer below the width, and pointer above the top
    drive_request(beat(MODE_PUSH, 2'd2, 17'h00003, '0, '1));
    drive_request(beat(MODE_PUSH, 2'd3, 17'h1ffff, '0, '1));
    drive_request(beat(MODE_PUSH, 2'd1, 17'h10001, '0, '1));
    drive_request(beat(MODE_POP,  2'd1, 17'h10000, '0, '0));
    drive_request(beat(MODE_POP,  2'd3, 17'h0fff9, '0, '0));
    drive_request(beat(MODE_POP,  2'd2, 17'h0fffc, '0, '0));
  endtask

  task automatic test_width_errors();
    drive_request(beat(MODE_PUSH, 2'd0, 17'h00100, '0, '1));
    // bad width wins over the range check
    drive_request(beat(MODE_POP,  2'd0, 17'h1ffff, '0, '0));
    drive_request(beat(MODE_PUSH, 2'd0, 17'h00000, '0, '1));
  endtask

  task automatic test_random_traffic(int unsigned count, int unsigned tx_pct,
                                     int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    sp_track = STACK_BYTES;
    repeat (count) drive_request(make_random_item());
  endtask

  // receiver holds off while requests keep coming, so the input backs up
  task automatic test_full_stall();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_request = 400;
    repeat (40) drive_request(make_random_item());
  endtask

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.mode = MODE_PUSH;
    req.width_code = '0;
    req.stack_pointer_in = '0;
    req.byte_address = '0;
    req.write_value = '0;
    for (int i = 0; i < STACK_BYTES; i++) begin
      mem_image[IDX_W'(i)] = GUARD_BYTE;
      mem_written[IDX_W'(i)] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_load_store_edges();
    test_push_pop_edges();
    test_width_errors();
    test_random_traffic(300, 0, 0);
    test_random_traffic(300, 77, 0);
    test_random_traffic(300, 0, 77);
    test_random_traffic(300, 19, 19);
    test_full_stall();

    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
